@@ hw/rtl/pipt_pkg.sv @@
`default_nettype none

package pipt_pkg;

  localparam int unsigned MaxVerticesDefault = 1024;
  localparam int unsigned MinPoly = 3;
  localparam logic signed [31:0] RayEndLon = 32'sd1810000000;
  localparam int unsigned HeldW = 11;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_ACW = 2'd2
  } orient_e;

  // The five orientation tests made for every edge.
  typedef enum logic [2:0] {
    TEST_EDGE_PT  = 3'd0,
    TEST_EDGE_END = 3'd1,
    TEST_RAY_A    = 3'd2,
    TEST_RAY_B    = 3'd3,
    TEST_COLLIN   = 3'd4
  } test_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FIRST, BK_LOAD, BK_ISSUE, BK_WAIT, BK_EVAL
  } bk_state_e;

  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [30:0] lat;
  } point_t;

  typedef struct packed {
    req_e   kind;
    point_t pt;
  } item_t;

  function automatic logic in_box(point_t a, point_t b, point_t p);
    logic signed [31:0] lo_lon, hi_lon;
    logic signed [30:0] lo_lat, hi_lat;
    lo_lon = (a.lon < b.lon) ? a.lon : b.lon;
    hi_lon = (a.lon < b.lon) ? b.lon : a.lon;
    lo_lat = (a.lat < b.lat) ? a.lat : b.lat;
    hi_lat = (a.lat < b.lat) ? b.lat : a.lat;
    return (p.lon <= hi_lon) && (p.lon >= lo_lon) && (p.lat <= hi_lat) && (p.lat >= lo_lat);
  endfunction

  function automatic logic crosses(orient_e d1, orient_e d2, orient_e d3, orient_e d4,
                                   point_t ea, point_t eb, point_t p, point_t r);
    logic res;
    res = 1'b0;
    if ((d1 != d2) && (d3 != d4)) res = 1'b1;
    if ((d1 == ORI_COL) && in_box(ea, eb, p)) res = 1'b1;
    if ((d2 == ORI_COL) && in_box(ea, eb, r)) res = 1'b1;
    if ((d3 == ORI_COL) && in_box(p, r, ea)) res = 1'b1;
    if ((d4 == ORI_COL) && in_box(p, r, eb)) res = 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pipt_front.sv @@
`default_nettype none

module pipt_front
  import pipt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire point_t      pt_i,
  output logic             q_valid_o,
  output item_t            q_item_o,
  input  wire logic        q_pop_i
);

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        push;
  item_t       item_in;

  always_comb begin
    item_in.pt = pt_i;
    case (req_type_i)
      REQ_APPEND: item_in.kind = REQ_APPEND;
      REQ_QUERY:  item_in.kind = REQ_QUERY;
      REQ_CLEAR:  item_in.kind = REQ_CLEAR;
      default:    item_in.kind = REQ_NOP;
    endcase
  end

  assign s_ready_o = (fill_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pipt_orient.sv @@
`default_nettype none

module pipt_orient
  import pipt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire test_e  tag_i,
  input  wire point_t a_i,
  input  wire point_t b_i,
  input  wire point_t c_i,
  output logic        valid_o,
  output test_e       tag_o,
  output orient_e     ori_o
);

  logic               v1_q, v2_q, v3_q;
  test_e              t1_q, t2_q, t3_q;
  logic signed [31:0] dlat1_q, dlat2_q;
  logic signed [32:0] dlon1_q, dlon2_q;
  logic signed [64:0] p_q, q_q;
  orient_e            ori_q;

  always_ff @(posedge clk_i) begin
    dlat1_q <= {b_i.lat[30], b_i.lat} - {a_i.lat[30], a_i.lat};
    dlon2_q <= {c_i.lon[31], c_i.lon} - {b_i.lon[31], b_i.lon};
    dlon1_q <= {b_i.lon[31], b_i.lon} - {a_i.lon[31], a_i.lon};
    dlat2_q <= {c_i.lat[30], c_i.lat} - {b_i.lat[30], b_i.lat};
    p_q     <= dlat1_q * dlon2_q;
    q_q     <= dlon1_q * dlat2_q;
    if (p_q == q_q) begin
      ori_q <= ORI_COL;
    end else if (p_q < q_q) begin
      ori_q <= ORI_ACW;
    end else begin
      ori_q <= ORI_CW;
    end
    t1_q <= tag_i;
    t2_q <= t1_q;
    t3_q <= t2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign tag_o   = t3_q;
  assign ori_o   = ori_q;

endmodule

`default_nettype wire

@@ hw/rtl/pipt_back.sv @@
`default_nettype none

module pipt_back
  import pipt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire item_t         q_item_i,
  output logic               q_pop_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic               inside_o,
  output logic               status_o,
  output logic [HeldW-1:0]   held_o
);

  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);

  bk_state_e       state_q, state_d;
  point_t          store [MAX_VERTICES];
  point_t          rd_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  point_t          wr_data;

  logic [CNTW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  point_t          pt_q, pt_d, first_q, first_d, ea_q, ea_d, eb_q, eb_d, ray;
  test_e           k_q, k_d;
  logic            par_q, par_d, cr;
  orient_e         d_q [5];

  logic            out_valid_q, out_inside_q, out_status_q;
  logic            set_out, res_inside, res_status;

  logic            ori_valid, res_valid;
  test_e           res_tag;
  orient_e         res_ori;
  point_t          oa, ob, oc;

  assign ray.lon = RayEndLon;
  assign ray.lat = pt_q.lat;

  always_comb begin
    case (k_q)
      TEST_EDGE_PT:  begin oa = ea_q; ob = eb_q; oc = pt_q; end
      TEST_EDGE_END: begin oa = ea_q; ob = eb_q; oc = ray;  end
      TEST_RAY_A:    begin oa = pt_q; ob = ray;  oc = ea_q; end
      TEST_RAY_B:    begin oa = pt_q; ob = ray;  oc = eb_q; end
      default:       begin oa = ea_q; ob = pt_q; oc = eb_q; end
    endcase
  end

  pipt_orient u_orient (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ori_valid),
    .tag_i   (k_q),
    .a_i     (oa),
    .b_i     (ob),
    .c_i     (oc),
    .valid_o (res_valid),
    .tag_o   (res_tag),
    .ori_o   (res_ori)
  );

  assign cr = crosses(d_q[0], d_q[1], d_q[2], d_q[3], ea_q, eb_q, pt_q, ray);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pt_d       = pt_q;
    first_d    = first_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    k_d        = k_q;
    par_d      = par_q;
    q_pop_o    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = cnt_q[AW-1:0];
    wr_data    = q_item_i.pt;
    ori_valid  = 1'b0;
    set_out    = 1'b0;
    res_inside = 1'b0;
    res_status = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          pt_d    = q_item_i.pt;
          case (q_item_i.kind)
            REQ_APPEND: begin
              set_out = 1'b1;
              if (cnt_q < CNTW'(MAX_VERTICES)) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end else begin
                res_status = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (cnt_q < CNTW'(MinPoly)) begin
                set_out = 1'b1;
              end else begin
                rd_en   = 1'b1;
                par_d   = 1'b0;
                state_d = BK_FIRST;
              end
            end
            REQ_CLEAR: begin
              set_out = 1'b1;
              cnt_d   = '0;
            end
            default: set_out = 1'b1;
          endcase
        end
      end
      BK_FIRST: begin
        first_d = rd_q;
        ea_d    = rd_q;
        idx_d   = CNTW'(1);
        rd_en   = 1'b1;
        rd_addr = AW'(1);
        state_d = BK_LOAD;
      end
      BK_LOAD: begin
        // The closing edge runs from the last vertex back to the first.
        eb_d    = (idx_q == cnt_q) ? first_q : rd_q;
        k_d     = TEST_EDGE_PT;
        state_d = BK_ISSUE;
      end
      BK_ISSUE: begin
        ori_valid = 1'b1;
        if (k_q == TEST_COLLIN) begin
          state_d = BK_WAIT;
        end else begin
          k_d = test_e'(k_q + 3'd1);
        end
      end
      BK_WAIT: begin
        if (res_valid && (res_tag == TEST_COLLIN)) state_d = BK_EVAL;
      end
      BK_EVAL: begin
        if (cr && (d_q[4] == ORI_COL)) begin
          set_out    = 1'b1;
          res_inside = in_box(ea_q, eb_q, pt_q);
          state_d    = BK_IDLE;
        end else if (idx_q == cnt_q) begin
          set_out    = 1'b1;
          res_inside = par_q ^ cr;
          state_d    = BK_IDLE;
        end else begin
          par_d   = par_q ^ cr;
          ea_d    = eb_q;
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_d[AW-1:0];
          state_d = BK_LOAD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (rd_en) rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    pt_q    <= pt_d;
    first_q <= first_d;
    ea_q    <= ea_d;
    eb_q    <= eb_d;
    k_q     <= k_d;
    par_q   <= par_d;
    idx_q   <= idx_d;
    if (res_valid) d_q[res_tag] <= res_ori;
    if (set_out) begin
      out_inside_q <= res_inside;
      out_status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (set_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign inside_o  = out_inside_q;
  assign status_o  = out_status_q;
  assign held_o    = HeldW'(cnt_q);

endmodule

`default_nettype wire

@@ hw/rtl/point_in_polygon_test_unit.sv @@
// Point-in-polygon unit: holds one polygon and answers point queries by ray casting.
// Input stream: s_axis_tuser carries the request (0 append vertex, 1 query point,
// 2 clear polygon, 3 ignored); s_axis_tdata carries longitude and latitude in
// 1e-7 degree units. Every transfer in produces exactly one transfer out on m_axis,
// in order, carrying the query answer, the full-store flag and the vertex count.
// A two-entry queue takes requests while the execution side is busy.
// A query over n vertices reads one vertex per edge from the vertex memory and
// runs five orientation tests on a three-stage multiplier pipeline per edge; an
// edge collinear with the point that also crosses the ray ends the walk early.
// Queries on fewer than three vertices answer at once.
// Reset empties the queue and the polygon; vertex memory is not cleared.
// While the receiver stalls, the result is held and the next request waits
// in the queue until the output register frees.
`default_nettype none

module point_in_polygon_test_unit
  import pipt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // coord_lon[31:0], coord_lat[62:32], zero
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // inside_res[0], status[1], vertices_held[12:2]
);

  logic             q_valid, q_pop;
  item_t            q_item;
  point_t           pt_in;
  logic             inside_res, status;
  logic [HeldW-1:0] held;

  assign pt_in.lon = s_axis_tdata[31:0];
  assign pt_in.lat = s_axis_tdata[62:32];

  pipt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .pt_i       (pt_in),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  pipt_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .inside_o  (inside_res),
    .status_o  (status),
    .held_o    (held)
  );

  assign m_axis_tdata = {3'b000, held, status, inside_res};

endmodule

`default_nettype wire
